FILE: hdl/ept_pkg.sv
// Shared types and codes for the emulated physical timer register block.
`timescale 1ns / 1ps
package ept_pkg;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register select codes
  localparam logic [1:0] SEL_CTL  = 2'd0;
  localparam logic [1:0] SEL_CMP  = 2'd1;
  localparam logic [1:0] SEL_TVAL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TIME_OFFSET = 1'b0;
  localparam logic CFG_READ_CLEARS = 1'b1;

  // Control register layout
  localparam int CTL_W      = 3;
  localparam int CTL_ENABLE = 0;
  localparam int CTL_IMASK  = 1;
  localparam int CTL_STATUS = 2;

  localparam int DATA_W = 64;
  localparam int TVAL_W = 32;

  // One input word
  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        reg_select;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] sys_count;
    logic              fiq_pending;
  } ept_item_t;

  // One result word
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_raise;
    logic              irq_clear;
  } ept_result_t;

endpackage

FILE: hdl/emulated_physical_timer_regs.sv
// Top level of the emulated physical timer register block.
// Each accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; timer state is updated as each word passes
// to the result register, and a stalled result holds the input register.
// Reset: synchronous active-low rst_n clears timer state, configuration
// and both valid flags.
`timescale 1ns / 1ps
module emulated_physical_timer_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_reg_select,
  input  logic [63:0] in_write_data,
  input  logic [63:0] in_sys_count,
  input  logic        in_fiq_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_data,
  output logic        out_irq_raise,
  output logic        out_irq_clear,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wr_data
);
  import ept_pkg::*;

  ept_item_t   in_item;
  ept_item_t   item;
  logic        item_valid;
  logic        advance;
  ept_result_t result;
  ept_result_t res_r;
  logic        out_valid_r, out_valid_nxt;

  assign in_item.op          = in_op;
  assign in_item.reg_select  = in_reg_select;
  assign in_item.write_data  = in_write_data;
  assign in_item.sys_count   = in_sys_count;
  assign in_item.fiq_pending = in_fiq_pending;

  // Move the held word on when the result register is free or draining
  assign advance = item_valid && (!out_valid_r || !out_stall);

  ept_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ept_timer_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .result      (result)
  );

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = res_r.read_data;
  assign out_irq_raise = res_r.irq_raise;
  assign out_irq_clear = res_r.irq_clear;

endmodule

FILE: hdl/ept_in_stage.sv
// Input register stage: holds one accepted word until the core consumes it.
`timescale 1ns / 1ps
module ept_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ept_pkg::ept_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output ept_pkg::ept_item_t item
);
  import ept_pkg::*;

  logic      valid_r, valid_nxt;
  ept_item_t item_r;
  logic      load;

  // Take a new word when empty or when the held word moves on
  assign load     = !valid_r || advance;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hdl/ept_timer_core.sv
// Timer state, configuration registers and per-word register access logic.
`timescale 1ns / 1ps
module ept_timer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_addr,
  input  logic [63:0]         cfg_wr_data,
  input  logic                advance,
  input  ept_pkg::ept_item_t  item,
  output ept_pkg::ept_result_t result
);
  import ept_pkg::*;

  logic [DATA_W-1:0] offset_r;
  logic              rd_clears_r;
  logic [CTL_W-1:0]  ctl_r, ctl_nxt;
  logic [DATA_W-1:0] cmp_r, cmp_nxt;
  logic              armed_r, armed_nxt;

  logic [DATA_W-1:0] cmp_view;
  logic [DATA_W-1:0] tval_diff;
  logic [DATA_W-1:0] cmp_from_data;
  logic [DATA_W-1:0] cmp_from_count;
  logic              expired;

  // Shared arithmetic, all wrapping at 64 bits
  assign cmp_view       = cmp_r - offset_r;
  assign tval_diff      = cmp_r - item.sys_count;
  assign cmp_from_data  = item.write_data + offset_r;
  assign cmp_from_count = item.sys_count + item.write_data;
  assign expired        = armed_r && (item.sys_count >= cmp_r);

  // Decode the word and compute next state and result
  always_comb begin
    ctl_nxt   = ctl_r;
    cmp_nxt   = cmp_r;
    armed_nxt = armed_r;
    result    = '0;
    unique case (item.op)
      OP_READ: begin
        unique case (item.reg_select)
          SEL_CTL: begin
            result.read_data = {{(DATA_W-CTL_W){1'b0}}, ctl_r};
            if (rd_clears_r && ctl_r[CTL_STATUS] && item.fiq_pending) begin
              ctl_nxt[CTL_STATUS] = 1'b0;
              result.irq_clear    = 1'b1;
            end
          end
          SEL_CMP:  result.read_data = cmp_view;
          SEL_TVAL: result.read_data = {{(DATA_W-TVAL_W){1'b0}}, tval_diff[TVAL_W-1:0]};
          default: ;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_select)
          SEL_CTL: begin
            // Drop written status; keep old status only while enabled
            ctl_nxt[CTL_ENABLE] = item.write_data[CTL_ENABLE];
            ctl_nxt[CTL_IMASK]  = item.write_data[CTL_IMASK];
            ctl_nxt[CTL_STATUS] = item.write_data[CTL_ENABLE] && ctl_r[CTL_STATUS];
            armed_nxt = item.write_data[CTL_ENABLE] && (cmp_r != '0);
          end
          SEL_CMP: begin
            cmp_nxt = cmp_from_data;
            if (ctl_r[CTL_ENABLE]) begin
              ctl_nxt[CTL_STATUS] = 1'b0;
              armed_nxt           = 1'b1;
            end
          end
          SEL_TVAL: begin
            cmp_nxt = cmp_from_count;
            if (ctl_r[CTL_ENABLE]) begin
              ctl_nxt[CTL_STATUS] = 1'b0;
              armed_nxt           = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        // Expire: set status, clear compare, disarm, raise unless masked
        if (expired) begin
          ctl_nxt[CTL_STATUS] = 1'b1;
          cmp_nxt             = '0;
          armed_nxt           = 1'b0;
          result.irq_raise    = !ctl_r[CTL_IMASK];
        end
      end
      default: ;
    endcase
  end

  // Timer state advances only when the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      cmp_r   <= '0;
      armed_r <= 1'b0;
    end else if (advance) begin
      ctl_r   <= ctl_nxt;
      cmp_r   <= cmp_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      rd_clears_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_TIME_OFFSET: offset_r    <= cfg_wr_data;
        CFG_READ_CLEARS: rd_clears_r <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

endmodule
